// File: rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// Holds the input and result transaction structs and the per-line walk state.
// No dependencies; every other file of the block uses it.
package lr_pkg;

    localparam int COORD_W = 10;
    localparam int PEN_W   = 32;
    localparam int ERR_W   = COORD_W + 2;
    localparam int REM_W   = COORD_W + 1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [PEN_W-1:0]   pen_in;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [PEN_W-1:0]   pen_out;
        logic               last_pixel;
    } out_item_t;

    typedef struct packed {
        logic                    busy;
        logic [COORD_W-1:0]      cur_x;
        logic [COORD_W-1:0]      cur_y;
        logic signed [ERR_W-1:0] err_acc;
        logic [COORD_W-1:0]      major_span;
        logic [COORD_W-1:0]      minor_span;
        logic [REM_W-1:0]        remaining;
        logic                    y_is_major;
        logic                    minor_down;
        logic [PEN_W-1:0]        pen_hold;
    } line_state_t;

endpackage

// File: rtl/line_rasterizer_top.sv
// Line rasterizer top level: input register, walk state and result register.
// Depends on lr_pkg, lr_setup and lr_step.
//
// A start transaction loads two endpoints and a pen value and yields the first
// pixel; each step transaction yields the next pixel until the one flagged
// last_pixel, and a step with no line running yields nothing. A line has
// max(major span, 1) pixels and the far endpoint is not drawn. A new
// transaction is accepted each cycle while results are taken. From
// acceptance to a valid result it passes the input register and then the
// result register, around the combinational error and coordinate update.
module line_rasterizer_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lr_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lr_pkg::out_item_t m_data
);

    logic                in_valid_reg;
    lr_pkg::in_item_t    in_reg;
    lr_pkg::line_state_t state_reg;
    logic                m_valid_reg;
    lr_pkg::out_item_t   m_data_reg;

    lr_pkg::line_state_t setup_state;
    lr_pkg::line_state_t work_state;
    lr_pkg::line_state_t step_next;
    lr_pkg::out_item_t   step_pixel;

    logic is_start;
    logic emits;
    logic out_free;
    logic proc_fire;

    lr_setup u_setup (
        .item       (in_reg),
        .init_state (setup_state)
    );

    lr_step u_step (
        .cur_state  (work_state),
        .pixel      (step_pixel),
        .next_state (step_next)
    );

    always_comb begin
        is_start   = (in_reg.func == lr_pkg::FUNC_START);
        emits      = is_start || state_reg.busy;
        out_free   = !m_valid_reg || m_ready;
        proc_fire  = in_valid_reg && (!emits || out_free);
        work_state = is_start ? setup_state : state_reg;
    end

    assign s_ready = !in_valid_reg || proc_fire;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (proc_fire && emits) begin
            state_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire && emits) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emits) begin
            m_data_reg <= step_pixel;
        end
    end

    a_busy_matches_count : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.busy == (state_reg.remaining != '0))
        else $error("busy flag disagrees with pixel count");

    a_err_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.busy |-> (state_reg.err_acc > 0) &&
            (state_reg.err_acc <= $signed({2'b00, state_reg.major_span})))
        else $error("error term left its range during a line");

    a_start_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && is_start) |=> m_valid_reg)
        else $error("start transaction produced no result");

    a_idle_step_silent : assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && !emits) |=> (m_valid_reg == $past(m_valid_reg && !m_ready)))
        else $error("step while idle changed the result channel");

endmodule

// File: rtl/lr_setup.sv
// Line setup logic: turns a start transaction into the initial walk state.
// Depends on lr_pkg for the transaction and state types.
module lr_setup (
    input  lr_pkg::in_item_t    item,
    output lr_pkg::line_state_t init_state
);

    localparam int CW = lr_pkg::COORD_W;

    logic [CW-1:0] x_len;
    logic [CW-1:0] y_len;
    logic          y_major;
    logic          swap;
    logic [CW-1:0] sx, sy, ox, oy;
    logic [CW-1:0] major;
    logic [CW-1:0] minor;

    always_comb begin
        x_len   = (item.x_start > item.x_end) ? (item.x_start - item.x_end)
                                              : (item.x_end - item.x_start);
        y_len   = (item.y_start > item.y_end) ? (item.y_start - item.y_end)
                                              : (item.y_end - item.y_start);
        y_major = (y_len > x_len);
        swap    = y_major ? (item.y_start > item.y_end) : (item.x_start > item.x_end);
        major   = y_major ? y_len : x_len;
        minor   = y_major ? x_len : y_len;

        sx = swap ? item.x_end   : item.x_start;
        sy = swap ? item.y_end   : item.y_start;
        ox = swap ? item.x_start : item.x_end;
        oy = swap ? item.y_start : item.y_end;

        init_state.busy       = 1'b1;
        init_state.cur_x      = sx;
        init_state.cur_y      = sy;
        init_state.err_acc    = $signed({2'b00, major});
        init_state.major_span = major;
        init_state.minor_span = minor;
        init_state.remaining  = (major != '0) ? {1'b0, major} : lr_pkg::REM_W'(1);
        init_state.y_is_major = y_major;
        init_state.minor_down = y_major ? (ox < sx) : (oy < sy);
        init_state.pen_hold   = item.pen_in;
    end

endmodule

// File: rtl/lr_step.sv
// Single pixel step: emits the current point and advances the error term.
// Depends on lr_pkg for the state and result types.
module lr_step (
    input  lr_pkg::line_state_t cur_state,
    output lr_pkg::out_item_t   pixel,
    output lr_pkg::line_state_t next_state
);

    localparam int CW = lr_pkg::COORD_W;
    localparam int EW = lr_pkg::ERR_W;
    localparam int RW = lr_pkg::REM_W;

    logic signed [EW-1:0] diff;
    logic                 wrap;
    logic [CW-1:0]        minor_coord;
    logic [CW-1:0]        minor_moved;
    logic [RW-1:0]        rem_next;

    always_comb begin
        pixel.pix_x      = cur_state.cur_x;
        pixel.pix_y      = cur_state.cur_y;
        pixel.pen_out    = cur_state.pen_hold;
        pixel.last_pixel = (cur_state.remaining == RW'(1));

        diff        = cur_state.err_acc - $signed({2'b00, cur_state.minor_span});
        wrap        = (diff <= 0);
        minor_coord = cur_state.y_is_major ? cur_state.cur_x : cur_state.cur_y;
        minor_moved = cur_state.minor_down ? (minor_coord - CW'(1))
                                           : (minor_coord + CW'(1));
        rem_next    = (cur_state.remaining != '0) ? (cur_state.remaining - RW'(1)) : '0;

        next_state         = cur_state;
        next_state.err_acc = wrap ? (diff + $signed({2'b00, cur_state.major_span})) : diff;
        if (cur_state.y_is_major) begin
            next_state.cur_y = cur_state.cur_y + CW'(1);
            if (wrap) begin
                next_state.cur_x = minor_moved;
            end
        end else begin
            next_state.cur_x = cur_state.cur_x + CW'(1);
            if (wrap) begin
                next_state.cur_y = minor_moved;
            end
        end
        next_state.remaining = rem_next;
        next_state.busy      = (rem_next != '0);
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer_top: directed table, then random line walks.
// Depends on lr_pkg and the line rasterizer RTL; predicts each pixel and checks it in order.
module testbench;

    localparam int ITEMS     = 1850;
    localparam int COORD_MAX = (1 << lr_pkg::COORD_W) - 1;
    localparam int HOLD_CYC  = 300;

    typedef logic [lr_pkg::COORD_W-1:0] coord_t;
    typedef logic [lr_pkg::PEN_W-1:0]   pen_t;

    typedef struct {
        bit                 busy;
        coord_t             cx;
        coord_t             cy;
        int                 err;
        coord_t             major;
        coord_t             minor;
        int                 remaining;
        bit                 y_major;
        bit                 down;
        pen_t               pen;
    } walk_t;

    typedef struct {
        lr_pkg::in_item_t  item;
        bit                typed;
        bit                typed_has;
        lr_pkg::out_item_t typed_pix;
    } stim_row_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    lr_pkg::in_item_t  s_data;
    logic              m_valid;
    logic              m_ready;
    lr_pkg::out_item_t m_data;

    walk_t             walk;
    lr_pkg::out_item_t pixel_q[$];
    stim_row_t         dir_rows[$];
    lr_pkg::out_item_t exp_pix;
    int                fail_count;
    int                items_sent;
    int                burst_left;
    int                n_starts;
    int                n_steps;
    int                n_idle_steps;
    int                n_pixels;
    int                n_lines_done;
    bit                hold_req;
    bit                hold_active;

    line_rasterizer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic lr_pkg::in_item_t line_item(int xs, int ys, int xe, int ye,
                                                   pen_t pen);
        lr_pkg::in_item_t it;
        it.func    = lr_pkg::FUNC_START;
        it.x_start = coord_t'(xs);
        it.y_start = coord_t'(ys);
        it.x_end   = coord_t'(xe);
        it.y_end   = coord_t'(ye);
        it.pen_in  = pen;
        return it;
    endfunction

    function automatic lr_pkg::in_item_t step_item();
        lr_pkg::in_item_t it;
        it.func    = lr_pkg::FUNC_STEP;
        it.x_start = coord_t'($urandom_range(0, COORD_MAX));
        it.y_start = coord_t'($urandom_range(0, COORD_MAX));
        it.x_end   = coord_t'($urandom_range(0, COORD_MAX));
        it.y_end   = coord_t'($urandom_range(0, COORD_MAX));
        it.pen_in  = $urandom;
        return it;
    endfunction

    function automatic lr_pkg::out_item_t pixel(int x, int y, pen_t pen, logic last);
        lr_pkg::out_item_t px;
        px.pix_x      = coord_t'(x);
        px.pix_y      = coord_t'(y);
        px.pen_out    = pen;
        px.last_pixel = last;
        return px;
    endfunction

    function automatic stim_row_t row(lr_pkg::in_item_t it, bit typed, bit has,
                                      lr_pkg::out_item_t px);
        stim_row_t r;
        r.item      = it;
        r.typed     = typed;
        r.typed_has = has;
        r.typed_pix = px;
        return r;
    endfunction

    function automatic int far_end(int base, int span);
        int v;
        v = $urandom_range(0, 1) ? base + span : base - span;
        if (v > COORD_MAX) v = base - span;
        if (v < 0) v = base + span;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    // Bresenham walk with the error seeded at the full major span.
    task automatic walk_predict(input lr_pkg::in_item_t it, output bit has,
                                output lr_pkg::out_item_t px);
        coord_t xlen;
        coord_t ylen;
        bit     swap;
        has = 1'b0;
        px  = '0;
        if (it.func == lr_pkg::FUNC_START) begin
            xlen = (it.x_start > it.x_end) ? it.x_start - it.x_end : it.x_end - it.x_start;
            ylen = (it.y_start > it.y_end) ? it.y_start - it.y_end : it.y_end - it.y_start;
            walk.y_major = (ylen > xlen);
            if (walk.y_major) begin
                swap       = (it.y_start > it.y_end);
                walk.major = ylen;
                walk.minor = xlen;
            end else begin
                swap       = (it.x_start > it.x_end);
                walk.major = xlen;
                walk.minor = ylen;
            end
            if (swap) begin
                walk.cx   = it.x_end;
                walk.cy   = it.y_end;
                walk.down = walk.y_major ? (it.x_start < it.x_end) : (it.y_start < it.y_end);
            end else begin
                walk.cx   = it.x_start;
                walk.cy   = it.y_start;
                walk.down = walk.y_major ? (it.x_end < it.x_start) : (it.y_end < it.y_start);
            end
            walk.err       = int'(walk.major);
            walk.remaining = (walk.major != 0) ? int'(walk.major) : 1;
            walk.pen       = it.pen_in;
            walk.busy      = 1'b1;
        end
        if (it.func == lr_pkg::FUNC_START || walk.busy) begin
            has           = 1'b1;
            px.pix_x      = walk.cx;
            px.pix_y      = walk.cy;
            px.pen_out    = walk.pen;
            px.last_pixel = (walk.remaining == 1);
            if (walk.y_major) walk.cy = walk.cy + 1'b1;
            else walk.cx = walk.cx + 1'b1;
            walk.err = walk.err - int'(walk.minor);
            if (walk.err <= 0) begin
                walk.err = walk.err + int'(walk.major);
                if (walk.y_major) walk.cx = walk.down ? walk.cx - 1'b1 : walk.cx + 1'b1;
                else walk.cy = walk.down ? walk.cy - 1'b1 : walk.cy + 1'b1;
            end
            if (walk.remaining > 0) walk.remaining--;
            walk.busy = (walk.remaining != 0);
        end
    endtask

    task automatic send(input lr_pkg::in_item_t it, input bit typed, input bit typed_has,
                        input lr_pkg::out_item_t typed_pix);
        bit                has;
        lr_pkg::out_item_t px;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        walk_predict(it, has, px);
        if (typed) begin
            has = typed_has;
            px  = typed_pix;
        end
        if (has) pixel_q.push_back(px);
        items_sent++;
        if (it.func == lr_pkg::FUNC_START) n_starts++;
        else begin
            n_steps++;
            if (!has) n_idle_steps++;
        end
        if (burst_left > 0 || hold_req || hold_active) begin
            if (burst_left > 0) burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                             input pen_t pen, input int nsteps);
        send(line_item(xs, ys, xe, ye, pen), 1'b0, 1'b0, '0);
        repeat (nsteps) send(step_item(), 1'b0, 1'b0, '0);
    endtask

    // The receiver switches among random stall patterns, and holds m_ready low during a requested hold.
    initial begin
        rx_mode_t mode;
        int       left;
        m_ready <= 1'b0;
        mode = RX_ALWAYS;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_active = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(32, 256);
                end
                left--;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 9) != 0);
                    default: m_ready <= (left % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_pixels++;
            if (m_data.last_pixel) n_lines_done++;
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel transaction: x=%0d y=%0d", m_data.pix_x, m_data.pix_y);
                fail_count++;
            end else begin
                exp_pix = pixel_q.pop_front();
                if (m_data.pix_x !== exp_pix.pix_x) begin
                    $error("pix_x: expected %0d, actual %0d", exp_pix.pix_x, m_data.pix_x);
                    fail_count++;
                end
                if (m_data.pix_y !== exp_pix.pix_y) begin
                    $error("pix_y: expected %0d, actual %0d", exp_pix.pix_y, m_data.pix_y);
                    fail_count++;
                end
                if (m_data.pen_out !== exp_pix.pen_out) begin
                    $error("pen_out: expected %h, actual %h", exp_pix.pen_out, m_data.pen_out);
                    fail_count++;
                end
                if (m_data.last_pixel !== exp_pix.last_pixel) begin
                    $error("last_pixel: expected %0b, actual %0b",
                           exp_pix.last_pixel, m_data.last_pixel);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int xs, ys, xe, ye, dx, dy, len, nsteps, size, span_lim, how;
        bit hold_done;
        bit drain_done;
        lr_pkg::in_item_t noise;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        walk = '{default: '0};
        fail_count   = 0;
        items_sent   = 0;
        burst_left   = 0;
        n_starts     = 0;
        n_steps      = 0;
        n_idle_steps = 0;
        n_pixels     = 0;
        n_lines_done = 0;
        hold_req     = 1'b0;
        hold_active  = 1'b0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;

        dir_rows.push_back(row(step_item(), 1, 0, '0));
        dir_rows.push_back(row(line_item(0, 0, 0, 0, 32'h0), 1, 1, pixel(0, 0, 32'h0, 1)));
        dir_rows.push_back(row(step_item(), 1, 0, '0));
        dir_rows.push_back(row(line_item(1023, 1023, 1023, 1023, 32'hFFFF_FFFF), 1, 1,
                               pixel(1023, 1023, 32'hFFFF_FFFF, 1)));
        dir_rows.push_back(row(line_item(0, 0, 1023, 1023, 32'hA5A5_A5A5), 1, 1,
                               pixel(0, 0, 32'hA5A5_A5A5, 0)));
        dir_rows.push_back(row(step_item(), 0, 0, '0));
        dir_rows.push_back(row(step_item(), 0, 0, '0));
        // A new line replaces one that is still running.
        dir_rows.push_back(row(line_item(1023, 0, 0, 1023, 32'h5A5A_5A5A), 1, 1,
                               pixel(0, 1023, 32'h5A5A_5A5A, 0)));
        dir_rows.push_back(row(step_item(), 0, 0, '0));
        dir_rows.push_back(row(step_item(), 0, 0, '0));
        // Slope of minus one, walked to the end and one step beyond.
        dir_rows.push_back(row(line_item(0, 5, 5, 0, 32'h1234_5678), 1, 1,
                               pixel(0, 5, 32'h1234_5678, 0)));
        repeat (5) dir_rows.push_back(row(step_item(), 0, 0, '0));
        dir_rows.push_back(row(line_item(3, 10, 5, 2, 32'hDEAD_BEEF), 1, 1,
                               pixel(5, 2, 32'hDEAD_BEEF, 0)));
        repeat (2) dir_rows.push_back(row(step_item(), 0, 0, '0));
        dir_rows.push_back(row(line_item(7, 7, 7, 8, 32'h0F0F_0F0F), 1, 1,
                               pixel(7, 7, 32'h0F0F_0F0F, 1)));
        dir_rows.push_back(row(step_item(), 1, 0, '0));
        dir_rows.push_back(row(line_item(9, 4, 8, 4, 32'hF0F0_F0F0), 1, 1,
                               pixel(8, 4, 32'hF0F0_F0F0, 1)));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_has,
                 dir_rows[i].typed_pix);

        draw_line(10, 40, 330, 200, $urandom, 319);

        while (items_sent < ITEMS) begin
            if (!hold_done && items_sent >= 700) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 1300) begin
                drain_done = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pixel_q.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 99) < 10) begin
                noise.func    = 1'($urandom_range(0, 1));
                noise.x_start = coord_t'($urandom_range(0, COORD_MAX));
                noise.y_start = coord_t'($urandom_range(0, COORD_MAX));
                noise.x_end   = coord_t'($urandom_range(0, COORD_MAX));
                noise.y_end   = coord_t'($urandom_range(0, COORD_MAX));
                noise.pen_in  = $urandom;
                send(noise, 1'b0, 1'b0, '0);
            end else begin
                size     = $urandom_range(0, 99);
                span_lim = (size < 85) ? 16 : ((size < 97) ? 200 : COORD_MAX);
                xs = $urandom_range(0, COORD_MAX);
                ys = $urandom_range(0, COORD_MAX);
                xe = far_end(xs, $urandom_range(0, span_lim));
                ye = far_end(ys, $urandom_range(0, span_lim));
                dx = (xs > xe) ? xs - xe : xe - xs;
                dy = (ys > ye) ? ys - ye : ye - ys;
                len = (dx > dy) ? dx : dy;
                if (len == 0) len = 1;
                how = $urandom_range(0, 99);
                if (how < 70) nsteps = len - 1;
                else if (how < 85) nsteps = len - 1 + $urandom_range(1, 3);
                else nsteps = (len > 1) ? $urandom_range(0, len - 2) : 0;
                if (nsteps > 120) nsteps = $urandom_range(20, 120);
                draw_line(xs, ys, xe, ye, $urandom, nsteps);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d line starts and %0d steps, %0d of them with no line running.",
                 n_starts, n_steps, n_idle_steps);
        $display("Compared %0d pixels; %0d lines reached their last pixel; %0d mismatches.",
                 n_pixels, n_lines_done, fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
